>>> rtl/per_subscriber_token_bucket_policer_macros.svh
// Assertion macros for the token bucket policer checker.
// No dependencies.
`ifndef PER_SUBSCRIBER_TOKEN_BUCKET_POLICER_MACROS_SVH
`define PER_SUBSCRIBER_TOKEN_BUCKET_POLICER_MACROS_SVH
`define TBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TBP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/tbp_pkg.sv
// Package for the token bucket policer: opcodes, status codes, widths.
// No dependencies.
package tbp_pkg;
    localparam logic [1:0] OP_PACKET  = 2'd0;
    localparam logic [1:0] OP_INSTALL = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam int ENTRY_W = 32 + 32 + 64 + 40 + 32 + 3;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    // floor(2^62 / 1e9); quotient estimate is exact or one low
    localparam logic [39:0] NS_RECIP = 40'((128'd1 << 62) / 128'd1000000000);
    // refill quotient saturates at 2^32 at or above this product
    localparam logic [127:0] REFILL_LIMIT = 128'h1_0000_0000 * 128'd1000000000;
    typedef struct packed {
        logic [2:0]  prio;
        logic [31:0] burst;
        logic [39:0] rate;
        logic [63:0] last_time;
        logic [31:0] tokens;
        logic [31:0] key;
    } entry_t;
endpackage

>>> rtl/tbp_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/per_subscriber_token_bucket_policer.sv
// Per-subscriber token bucket policer, top level. Uses tbp_pkg, tbp_ram.
// An input transfer is registered, then the table is scanned, one entry a cycle,
// before m_tvalid; a policed packet with nonzero rate first takes three passes of
// the shared shift-add multiplier, or only the first pass if the refill saturates.
// One item at a time: no new input is taken until the result is accepted.
// Reset clears valid bits and counters at once; no clearing pass.
module per_subscriber_token_bucket_policer #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: opcode[1:0] direction[2] is_ipv4[3] subscriber_ip[35:4]
    // packet_length[51:36] now_ns[115:52] policy_rate_bps[155:116]
    // policy_burst_bytes[187:156] policy_priority[190:188]
    // policy_initial_tokens[222:191], zero padded to 224
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: verdict[0] priority_out[3:1] policy_found[4] op_status[6:5]
    // pass_pkt_total[70:7] drop_pkt_total[134:71]
    // pass_byte_total[198:135] drop_byte_total[262:199], padded to 264
    output logic [263:0] m_tdata
);
    localparam int AW = $clog2(2 * TABLE_DEPTH);
    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DEC = 4'd2, S_MUL = 4'd3,
                           S_NEXT = 4'd4, S_UPD = 4'd5, S_OUT = 4'd6;
    localparam logic [1:0] P_REFILL = 2'd0, P_RECIP = 2'd1, P_BACK = 2'd2;

    function automatic logic [AW-1:0] slot_addr(logic d, logic [IW-1:0] i);
        return d ? AW'(TABLE_DEPTH) + AW'(i) : AW'(i);
    endfunction

    logic [3:0] state_reg, state_next;
    logic [223:0] in_reg;
    logic [2*TABLE_DEPTH-1:0] valid_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic rd_v_reg;
    logic hit_reg, free_v_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    tbp_pkg::entry_t hit_e_reg;
    logic [127:0] prod_reg;
    logic [63:0] mcand_reg;
    logic [39:0] mplier_reg;
    logic [6:0] cnt_reg;
    logic [1:0] pass_reg;
    logic [61:0] dvd_reg;
    logic [32:0] q_reg;
    logic [63:0] ppc_reg, dpc_reg, pbc_reg, dbc_reg;
    logic verdict_reg, found_reg;
    logic [2:0] prio_reg;
    logic [1:0] status_reg;

    logic [1:0]  opc;
    logic        dir, ipv4;
    logic [31:0] key;
    logic [15:0] len;
    logic [63:0] now;
    assign opc  = in_reg[1:0];
    assign dir  = in_reg[2];
    assign ipv4 = in_reg[3];
    assign key  = in_reg[35:4];
    assign len  = in_reg[51:36];
    assign now  = in_reg[115:52];

    logic we;
    logic [AW-1:0] waddr, raddr;
    tbp_pkg::entry_t wdata, rdata;
    logic [$bits(tbp_pkg::entry_t)-1:0] rdata_raw;
    assign rdata = rdata_raw;
    assign raddr = slot_addr(dir, idx_reg);

    tbp_ram #(.WIDTH($bits(tbp_pkg::entry_t)), .DEPTH(2 * TABLE_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata_raw)
    );

    logic [AW-1:0] rd_addr;
    assign rd_addr = slot_addr(dir, rd_idx_reg);

    // remainder still at or above 1e9: quotient estimate was one low
    logic q_inc;
    assign q_inc = (dvd_reg - prod_reg[61:0]) >= {32'd0, tbp_pkg::NS_PER_SEC};

    logic [32:0] tsum;
    logic [32:0] tcap;
    assign tsum = {1'b0, hit_e_reg.tokens} + q_reg;
    assign tcap = (tsum > {1'b0, hit_e_reg.burst}) ? {1'b0, hit_e_reg.burst} : tsum;

    logic [AW-1:0] hit_addr, free_addr;
    assign hit_addr  = slot_addr(dir, hit_idx_reg);
    assign free_addr = slot_addr(dir, free_idx_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_SCAN;
            S_SCAN: if (!(idx_reg < IW'(TABLE_DEPTH)) && !rd_v_reg) state_next = S_DEC;
            S_DEC: begin
                if (opc == tbp_pkg::OP_PACKET && ipv4 && hit_reg && hit_e_reg.rate != 40'd0)
                    state_next = S_MUL;
                else
                    state_next = S_OUT;
            end
            S_MUL: if (cnt_reg == 7'd0) state_next = S_NEXT;
            S_NEXT: begin
                if (pass_reg == P_BACK ||
                    (pass_reg == P_REFILL && prod_reg >= tbp_pkg::REFILL_LIMIT))
                    state_next = S_UPD;
                else
                    state_next = S_MUL;
            end
            S_UPD: state_next = S_OUT;
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        we = 1'b0;
        waddr = hit_addr;
        wdata = hit_e_reg;
        if (state_reg == S_DEC) begin
            if (opc == tbp_pkg::OP_INSTALL && (hit_reg || free_v_reg)) begin
                we = 1'b1;
                waddr = hit_reg ? hit_addr : free_addr;
                wdata.key = key;
                wdata.tokens = in_reg[222:191];
                wdata.last_time = now;
                wdata.rate = in_reg[155:116];
                wdata.burst = in_reg[187:156];
                wdata.prio = in_reg[190:188];
            end
        end else if (state_reg == S_UPD) begin
            we = 1'b1;
            wdata.last_time = now;
            wdata.tokens = (tcap >= {17'd0, len}) ? 32'(tcap - {17'd0, len}) : tcap[31:0];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {1'b0, dbc_reg, pbc_reg, dpc_reg, ppc_reg, status_reg, found_reg,
                      prio_reg, verdict_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            ppc_reg <= '0; dpc_reg <= '0; pbc_reg <= '0; dbc_reg <= '0;
            rd_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    in_reg <= s_tdata;
                    idx_reg <= '0;
                    rd_v_reg <= 1'b0;
                    hit_reg <= 1'b0;
                    free_v_reg <= 1'b0;
                end
                S_SCAN: begin
                    rd_v_reg <= idx_reg < IW'(TABLE_DEPTH);
                    rd_idx_reg <= idx_reg;
                    if (idx_reg < IW'(TABLE_DEPTH)) idx_reg <= idx_reg + 1'b1;
                    if (rd_v_reg) begin
                        if (valid_reg[rd_addr]) begin
                            if (!hit_reg && rdata.key == key) begin
                                hit_reg <= 1'b1;
                                hit_idx_reg <= rd_idx_reg;
                                hit_e_reg <= rdata;
                            end
                        end else if (!free_v_reg) begin
                            free_v_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                    end
                end
                S_DEC: begin
                    verdict_reg <= 1'b0;
                    prio_reg <= 3'd0;
                    found_reg <= 1'b0;
                    status_reg <= tbp_pkg::ST_OK;
                    mcand_reg <= now - hit_e_reg.last_time;
                    mplier_reg <= {3'd0, hit_e_reg.rate[39:3]};
                    prod_reg <= '0;
                    cnt_reg <= 7'd39;
                    pass_reg <= P_REFILL;
                    case (opc)
                        tbp_pkg::OP_PACKET: if (ipv4 && hit_reg) begin
                            found_reg <= 1'b1;
                            if (hit_e_reg.rate == 40'd0) begin
                                ppc_reg <= ppc_reg + 64'd1;
                                pbc_reg <= pbc_reg + {48'd0, len};
                                if (!dir) prio_reg <= hit_e_reg.prio;
                            end
                        end
                        tbp_pkg::OP_INSTALL: begin
                            found_reg <= hit_reg;
                            if (hit_reg || free_v_reg)
                                valid_reg[hit_reg ? hit_addr : free_addr] <= 1'b1;
                            else
                                status_reg <= tbp_pkg::ST_FULL;
                        end
                        tbp_pkg::OP_REMOVE: begin
                            found_reg <= hit_reg;
                            if (hit_reg) valid_reg[hit_addr] <= 1'b0;
                            else status_reg <= tbp_pkg::ST_MISSING;
                        end
                        default: ;
                    endcase
                end
                S_MUL: begin
                    // shift-add, multiplier MSB first
                    prod_reg <= {prod_reg[126:0], 1'b0} +
                                (mplier_reg[39] ? {64'd0, mcand_reg} : 128'd0);
                    mplier_reg <= {mplier_reg[38:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                end
                S_NEXT: begin
                    prod_reg <= '0;
                    cnt_reg <= 7'd39;
                    unique case (pass_reg)
                        P_REFILL: begin
                            if (prod_reg >= tbp_pkg::REFILL_LIMIT) q_reg <= {1'b1, 32'd0};
                            dvd_reg <= prod_reg[61:0];
                            mcand_reg <= {2'd0, prod_reg[61:0]};
                            mplier_reg <= tbp_pkg::NS_RECIP;
                            pass_reg <= P_RECIP;
                        end
                        P_RECIP: begin
                            q_reg <= {1'b0, prod_reg[93:62]};
                            mcand_reg <= {32'd0, prod_reg[93:62]};
                            mplier_reg <= {10'd0, tbp_pkg::NS_PER_SEC};
                            pass_reg <= P_BACK;
                        end
                        P_BACK: q_reg <= q_reg + {32'd0, q_inc};
                        default: ;
                    endcase
                end
                S_UPD: begin
                    if (tcap >= {17'd0, len}) begin
                        ppc_reg <= ppc_reg + 64'd1;
                        pbc_reg <= pbc_reg + {48'd0, len};
                        if (!dir) prio_reg <= hit_e_reg.prio;
                    end else begin
                        verdict_reg <= 1'b1;
                        dpc_reg <= dpc_reg + 64'd1;
                        dbc_reg <= dbc_reg + {48'd0, len};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> rtl/tbp_checker.sv
// Port-level checker for the token bucket policer, bound to the top level.
// Uses per_subscriber_token_bucket_policer_macros.svh.
`include "per_subscriber_token_bucket_policer_macros.svh"
module tbp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [263:0] m_tdata
);
    `TBP_ASSERT(a_excl, aclk, aresetn, !(s_tready && m_tvalid), "ready during result")
    `TBP_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result moved")
    `TBP_ASSERT(a_drop_prio, aclk, aresetn, m_tvalid && m_tdata[0] |-> m_tdata[3:1] == 3'd0, "prio on drop")
    `TBP_ASSERT(a_idle, aclk, aresetn, s_tready && !s_tvalid |=> s_tready, "left idle")
    `TBP_ASSERT_RST(a_rst, aclk, !aresetn |=> s_tready && !m_tvalid, "reset state")
endmodule

bind per_subscriber_token_bucket_policer tbp_checker u_tbp_checker (.*);
